/* src/scc_pkg.sv */
// Shared constants for the sensor channel conditioner: field widths, opcodes,
// channel and register codes, check limits and reset values.
// No dependencies.
`default_nettype none

package scc_pkg;

    localparam int DATA_W     = 16;
    localparam int WINDOW_DEF = 8;

    localparam logic [2:0] OP_CO2      = 3'd0;
    localparam logic [2:0] OP_CO2_POLL = 3'd1;
    localparam logic [2:0] OP_LIGHT    = 3'd2;
    localparam logic [2:0] OP_SOIL     = 3'd3;
    localparam logic [2:0] OP_CLIMATE  = 3'd4;

    localparam logic [1:0] CH_CLIMATE = 2'd0;
    localparam logic [1:0] CH_CO2     = 2'd1;
    localparam logic [1:0] CH_LIGHT   = 2'd2;
    localparam logic [1:0] CH_SOIL    = 2'd3;

    localparam logic [1:0] REG_CO2_MAX    = 2'd0;
    localparam logic [1:0] REG_FAIL_LIMIT = 2'd1;
    localparam logic [1:0] REG_CO2_STALE  = 2'd2;

    localparam logic [15:0] CO2_MAX_RST    = 16'd5000;
    localparam logic [7:0]  FAIL_LIMIT_RST = 8'd3;
    localparam logic [15:0] CO2_STALE_RST  = 16'd5000;
    localparam logic [7:0]  STATUS_RST     = 8'h0F;

    localparam logic [11:0]        ADC_SAT  = 12'hFFF;
    localparam logic signed [15:0] TEMP_MIN = -16'sd400;
    localparam logic signed [15:0] TEMP_MAX = 16'sd800;
    localparam logic [15:0]        HUM_MAX  = 16'd1000;
    localparam logic [15:0]        TEMP_OFS = 16'd400;
    localparam logic [7:0]         FAIL_SAT = 8'hFF;

endpackage

`default_nettype wire

/* src/scc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire                                     clk,
    input  wire                                     wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                         wr_data,
    input  wire                                     rd_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/scc_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies.
`default_nettype none

module scc_serdiv #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  wire [NUM_W-1:0]  num,
    input  wire [DEN_W-1:0]  den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic             rem_nz
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign quot   = num_reg;
    assign rem_nz = |rem_reg;

`ifndef SYNTH
    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_den_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (den != '0))
        else $error("divider started with zero divisor");
    a_rem_below : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");
    a_done_end : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while still iterating");
`endif

endmodule

`default_nettype wire

/* src/scc_window.sv */
// Moving-average window: sample RAM, running sum, fill count and write position,
// feeding a bit-serial divider. Uses scc_pkg, scc_ram and scc_serdiv.
`default_nettype none

module scc_window #(
    parameter int WINDOW = scc_pkg::WINDOW_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  wire [scc_pkg::DATA_W-1:0]    data,
    output logic                         done,
    output logic [scc_pkg::DATA_W-1:0]   avg,
    output logic                         rem_nz
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = scc_pkg::DATA_W + $clog2(WINDOW);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_UPD  = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [scc_pkg::DATA_W-1:0] data_reg, data_next;
    logic [scc_pkg::DATA_W-1:0] ram_rd_data;
    logic [scc_pkg::DATA_W-1:0] old;
    logic [SUM_W-1:0]           sum_new;
    logic [CNT_W-1:0]           fill_new;
    logic                       full;
    logic                       ram_wr;
    logic                       ram_rd;
    logic                       div_start;
    logic                       div_done;
    logic [SUM_W-1:0]           div_quot;

    always_comb
    begin
        full       = fill_reg == CNT_W'(WINDOW);
        old        = full ? ram_rd_data : '0;
        sum_new    = sum_reg - SUM_W'(old) + SUM_W'(data_reg);
        fill_new   = full ? fill_reg : fill_reg + 1'b1;
        ram_rd     = push && (state_reg == W_IDLE);
        state_next = state_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        data_next  = data_reg;
        ram_wr     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (push)
                begin
                    data_next  = data;
                    state_next = W_UPD;
                end
            end
            W_UPD:
            begin
                ram_wr     = 1'b1;
                div_start  = 1'b1;
                sum_next   = sum_new;
                fill_next  = fill_new;
                pos_next   = (pos_reg == AW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                state_next = W_DIV;
            end
            W_DIV:
            begin
                if (div_done)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    scc_ram #(
        .WIDTH (scc_pkg::DATA_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (pos_reg),
        .wr_data (data_reg),
        .rd_en   (ram_rd),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    scc_serdiv #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (sum_new),
        .den    (fill_new),
        .done   (div_done),
        .quot   (div_quot),
        .rem_nz (rem_nz)
    );

    assign done = div_done;
    assign avg  = div_quot[scc_pkg::DATA_W-1:0];

`ifndef SYNTH
    a_push_idle : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (state_reg == W_IDLE))
        else $error("sample pushed while window busy");
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window depth");
    a_pos_tracks_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != CNT_W'(WINDOW)) |-> (CNT_W'(pos_reg) == fill_reg))
        else $error("write position out of step with fill count");
`endif

endmodule

`default_nettype wire

/* src/sensor_channel_conditioner_core.sv */
// Sensor channel conditioner top level: event decode, range checks, failure
// counters, status, APB registers and result register. Uses scc_pkg, scc_window.
//
// Each input word is one sensor event and yields one result word, the snapshot of
// all channels and the status byte. CO2 and poll events, rejected readings and
// unknown opcodes go from accept to the done state, which loads the output register
// once it is free. A good light, soil or climate reading first goes through its
// moving-average window and a bit-serial divider that resolves one quotient bit per
// cycle over the window sum. Climate readings run the temperature and humidity
// windows side by side. A finished result waits in the output register while the
// next word is accepted.
`default_nettype none

module sensor_channel_conditioner_core #(
    parameter int WINDOW = scc_pkg::WINDOW_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [3:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [2:0]          opcode,
    input  wire                read_ok,
    input  wire [15:0]         reading,
    input  wire signed [15:0]  temp_tenths_in,
    input  wire [11:0]         light_adc_raw,
    input  wire [31:0]         now_ms,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [15:0]        co2_value,
    output logic [15:0]        lux_avg,
    output logic [15:0]        soil_avg,
    output logic signed [10:0] temp_avg,
    output logic [9:0]         humidity_avg,
    output logic [7:0]         status_bits
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [15:0] co2_max_reg, co2_max_next;
    logic [7:0]  fail_limit_reg, fail_limit_next;
    logic [15:0] co2_stale_reg, co2_stale_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  fail_cnt_reg [4];
    logic [7:0]  fail_cnt_next [4];
    logic [31:0] co2_last_reg, co2_last_next;
    logic [15:0] co2_val_reg, co2_val_next;
    logic [15:0] lux_avg_reg, lux_avg_next;
    logic [15:0] soil_avg_reg, soil_avg_next;
    logic [10:0] temp_avg_reg, temp_avg_next;
    logic [9:0]  hum_avg_reg, hum_avg_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_co2_reg, out_lux_reg, out_soil_reg;
    logic [10:0] out_temp_reg;
    logic [9:0]  out_hum_reg;
    logic [7:0]  out_status_reg;
    logic        out_load;

    logic        accept;
    logic        cfg_wr;
    logic        co2_good, light_good, climate_good, stale;
    logic [31:0] age;
    logic        rec_en, rec_ok;
    logic [1:0]  rec_ch;
    logic [7:0]  rec_cnt, rec_inc;
    logic        push_lux, push_soil, push_clim, any_push;
    logic [15:0] temp_ofs;
    logic        lux_done, soil_done, hum_done, temp_done, any_done;
    logic [15:0] lux_q, soil_q, hum_q, temp_q;
    logic        temp_rnz;
    logic        lux_rnz_unused, soil_rnz_unused, hum_rnz_unused;
    logic [15:0] temp_val;

    assign accept   = in_valid && in_ready;
    assign in_ready = state_reg == S_IDLE;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign temp_ofs = 16'(temp_tenths_in) + scc_pkg::TEMP_OFS;
    assign any_done = lux_done || soil_done || hum_done || temp_done;

    always_comb
    begin
        unique case (paddr[3:2])
            scc_pkg::REG_CO2_MAX:    prdata = {16'd0, co2_max_reg};
            scc_pkg::REG_FAIL_LIMIT: prdata = {24'd0, fail_limit_reg};
            scc_pkg::REG_CO2_STALE:  prdata = {16'd0, co2_stale_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        co2_max_next    = co2_max_reg;
        fail_limit_next = fail_limit_reg;
        co2_stale_next  = co2_stale_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                scc_pkg::REG_CO2_MAX:    co2_max_next    = pwdata[15:0];
                scc_pkg::REG_FAIL_LIMIT: fail_limit_next = pwdata[7:0];
                scc_pkg::REG_CO2_STALE:  co2_stale_next  = pwdata[15:0];
                default:                 co2_max_next    = co2_max_reg;
            endcase
        end
    end

    always_comb
    begin
        co2_good     = read_ok && (reading != 16'd0) && (reading <= co2_max_reg);
        age          = now_ms - co2_last_reg;
        stale        = age >= {16'd0, co2_stale_reg};
        light_good   = read_ok && (light_adc_raw != scc_pkg::ADC_SAT);
        climate_good = read_ok && (temp_tenths_in >= scc_pkg::TEMP_MIN)
                       && (temp_tenths_in <= scc_pkg::TEMP_MAX)
                       && (reading <= scc_pkg::HUM_MAX);
        rec_en    = 1'b0;
        rec_ok    = 1'b0;
        rec_ch    = scc_pkg::CH_CO2;
        push_lux  = 1'b0;
        push_soil = 1'b0;
        push_clim = 1'b0;
        unique case (opcode)
            scc_pkg::OP_CO2:
            begin
                rec_en = 1'b1;
                rec_ok = co2_good;
            end
            scc_pkg::OP_CO2_POLL:
            begin
                rec_en = stale;
            end
            scc_pkg::OP_LIGHT:
            begin
                rec_en   = 1'b1;
                rec_ch   = scc_pkg::CH_LIGHT;
                rec_ok   = light_good;
                push_lux = light_good;
            end
            scc_pkg::OP_SOIL:
            begin
                rec_en    = 1'b1;
                rec_ch    = scc_pkg::CH_SOIL;
                rec_ok    = read_ok;
                push_soil = read_ok;
            end
            scc_pkg::OP_CLIMATE:
            begin
                rec_en    = 1'b1;
                rec_ch    = scc_pkg::CH_CLIMATE;
                rec_ok    = climate_good;
                push_clim = climate_good;
            end
            default:
            begin
                rec_en = 1'b0;
            end
        endcase
        any_push = push_lux || push_soil || push_clim;
    end

    // failure bookkeeping for the channel this word touches, and the latest good CO2 value and time
    always_comb
    begin
        rec_cnt       = fail_cnt_reg[rec_ch];
        rec_inc       = rec_cnt + 8'd1;
        status_next   = status_reg;
        fail_cnt_next = fail_cnt_reg;
        co2_val_next  = co2_val_reg;
        co2_last_next = co2_last_reg;
        if (accept && rec_en)
        begin
            if (rec_ok)
            begin
                status_next[{1'b0, rec_ch}] = 1'b0;
                status_next[{1'b1, rec_ch}] = 1'b0;
                fail_cnt_next[rec_ch]       = 8'd0;
            end
            else
            begin
                status_next[{1'b0, rec_ch}] = 1'b1;
                if (rec_cnt != scc_pkg::FAIL_SAT)
                begin
                    fail_cnt_next[rec_ch] = rec_inc;
                    if (rec_inc >= fail_limit_reg)
                    begin
                        status_next[{1'b1, rec_ch}] = 1'b1;
                    end
                end
            end
        end
        if (accept && (opcode == scc_pkg::OP_CO2) && co2_good)
        begin
            co2_val_next  = reading;
            co2_last_next = now_ms;
        end
    end

    always_comb
    begin
        temp_val      = temp_q - scc_pkg::TEMP_OFS
                        + {15'd0, (temp_q < scc_pkg::TEMP_OFS) && temp_rnz};
        lux_avg_next  = lux_done ? lux_q : lux_avg_reg;
        soil_avg_next = soil_done ? soil_q : soil_avg_reg;
        hum_avg_next  = hum_done ? hum_q[9:0] : hum_avg_reg;
        temp_avg_next = temp_done ? temp_val[10:0] : temp_avg_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = any_push ? S_BUSY : S_DONE;
                end
            end
            S_BUSY:
            begin
                if (any_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            co2_max_reg    <= scc_pkg::CO2_MAX_RST;
            fail_limit_reg <= scc_pkg::FAIL_LIMIT_RST;
            co2_stale_reg  <= scc_pkg::CO2_STALE_RST;
            status_reg     <= scc_pkg::STATUS_RST;
            fail_cnt_reg   <= '{default: 8'd0};
            co2_last_reg   <= '0;
            co2_val_reg    <= '0;
            lux_avg_reg    <= '0;
            soil_avg_reg   <= '0;
            temp_avg_reg   <= '0;
            hum_avg_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            co2_max_reg    <= co2_max_next;
            fail_limit_reg <= fail_limit_next;
            co2_stale_reg  <= co2_stale_next;
            status_reg     <= status_next;
            fail_cnt_reg   <= fail_cnt_next;
            co2_last_reg   <= co2_last_next;
            co2_val_reg    <= co2_val_next;
            lux_avg_reg    <= lux_avg_next;
            soil_avg_reg   <= soil_avg_next;
            temp_avg_reg   <= temp_avg_next;
            hum_avg_reg    <= hum_avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_co2_reg    <= co2_val_reg;
            out_lux_reg    <= lux_avg_reg;
            out_soil_reg   <= soil_avg_reg;
            out_temp_reg   <= temp_avg_reg;
            out_hum_reg    <= hum_avg_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign co2_value    = out_co2_reg;
    assign lux_avg      = out_lux_reg;
    assign soil_avg     = out_soil_reg;
    assign temp_avg     = out_temp_reg;
    assign humidity_avg = out_hum_reg;
    assign status_bits  = out_status_reg;

    scc_window #(.WINDOW (WINDOW)) u_lux (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && push_lux),
        .data   (reading),
        .done   (lux_done),
        .avg    (lux_q),
        .rem_nz (lux_rnz_unused)
    );

    scc_window #(.WINDOW (WINDOW)) u_soil (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && push_soil),
        .data   (reading),
        .done   (soil_done),
        .avg    (soil_q),
        .rem_nz (soil_rnz_unused)
    );

    scc_window #(.WINDOW (WINDOW)) u_hum (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && push_clim),
        .data   (reading),
        .done   (hum_done),
        .avg    (hum_q),
        .rem_nz (hum_rnz_unused)
    );

    // temperature is stored offset to be non-negative; fix truncation toward zero
    scc_window #(.WINDOW (WINDOW)) u_temp (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && push_clim),
        .data   (temp_ofs),
        .done   (temp_done),
        .avg    (temp_q),
        .rem_nz (temp_rnz)
    );

`ifndef SYNTH
    a_fault_needs_invalid : assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg[7:4] & ~status_reg[3:0]) == 4'd0)
        else $error("fault bit set without invalid bit");
    a_count_needs_invalid : assert property (@(posedge clk) disable iff (!rst_n)
        !(((fail_cnt_reg[0] != 8'd0) && !status_reg[0])
          || ((fail_cnt_reg[1] != 8'd0) && !status_reg[1])
          || ((fail_cnt_reg[2] != 8'd0) && !status_reg[2])
          || ((fail_cnt_reg[3] != 8'd0) && !status_reg[3])))
        else $error("failure count held on a valid channel");
    a_done_when_busy : assert property (@(posedge clk) disable iff (!rst_n)
        any_done |-> (state_reg == S_BUSY))
        else $error("average finished outside busy state");
    a_clim_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
        hum_done == temp_done)
        else $error("climate windows out of step");
`endif

endmodule

`default_nettype wire

/* dv/scc_snapshot_checker.sv */
`timescale 1ns / 100ps
// Snapshot checker for the sensor channel conditioner: checks register reads against
// tracked writes, predicts each snapshot from the accepted event words and compares
// it field by field. Uses scc_pkg opcodes, channel and register codes and check limits.

module scc_snapshot_checker (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [3:0]         paddr,
    input  wire [31:0]        pwdata,
    input  wire [31:0]        prdata,
    input  wire               pready,
    input  wire               in_valid,
    input  wire               in_ready,
    input  wire [2:0]         opcode,
    input  wire               read_ok,
    input  wire [15:0]        reading,
    input  wire signed [15:0] temp_tenths_in,
    input  wire [11:0]        light_adc_raw,
    input  wire [31:0]        now_ms,
    input  wire               out_valid,
    input  wire               out_ready,
    input  wire [15:0]        co2_value,
    input  wire [15:0]        lux_avg,
    input  wire [15:0]        soil_avg,
    input  wire signed [10:0] temp_avg,
    input  wire [9:0]         humidity_avg,
    input  wire [7:0]         status_bits,
    output int                fail_count,
    output int                pending_words,
    output int                checked_words
);

    import scc_pkg::*;

    localparam int WIN_DEPTH = WINDOW_DEF;
    localparam int WIN_LUX   = 0;
    localparam int WIN_SOIL  = 1;
    localparam int WIN_HUM   = 2;
    localparam int WIN_TEMP  = 3;

    typedef struct packed {
        logic [15:0] co2;
        logic [15:0] lux;
        logic [15:0] soil;
        logic [10:0] temp;
        logic [9:0]  hum;
        logic [7:0]  status;
    } snapshot_t;

    logic [15:0] co2_max_q;
    logic [7:0]  fail_limit_q;
    logic [15:0] stale_q;

    logic [15:0] window_q [4][WIN_DEPTH];
    int          fill_q [4];
    int          wpos_q [4];
    int          fail_cnt_q [4];
    logic [7:0]  status_q;
    logic [15:0] co2_q;
    logic [15:0] lux_q;
    logic [15:0] soil_q;
    logic [15:0] temp_q;
    logic [15:0] hum_q;
    logic [31:0] co2_seen_ms;

    snapshot_t   expected_snapshots [$];
    snapshot_t   exp_snap;

    function automatic void reset_model();
        int i;
        co2_max_q    = CO2_MAX_RST;
        fail_limit_q = FAIL_LIMIT_RST;
        stale_q      = CO2_STALE_RST;
        status_q     = STATUS_RST;
        for (i = 0; i < 4; i++)
        begin
            fill_q[i]     = 0;
            wpos_q[i]     = 0;
            fail_cnt_q[i] = 0;
        end
        co2_q       = '0;
        lux_q       = '0;
        soil_q      = '0;
        temp_q      = '0;
        hum_q       = '0;
        co2_seen_ms = '0;
    endfunction

    function automatic logic [31:0] read_register(logic [1:0] idx);
        case (idx)
            REG_CO2_MAX:    return {16'd0, co2_max_q};
            REG_FAIL_LIMIT: return {24'd0, fail_limit_q};
            REG_CO2_STALE:  return {16'd0, stale_q};
            default:        return 32'd0;
        endcase
    endfunction

    function automatic void write_register(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_CO2_MAX:    co2_max_q    = data[15:0];
            REG_FAIL_LIMIT: fail_limit_q = data[7:0];
            REG_CO2_STALE:  stale_q      = data[15:0];
            default:        ;
        endcase
    endfunction

    // push one sample and return the mean of the samples present, truncated toward zero
    function automatic int push_sample(int w, logic [15:0] v);
        int sum;
        int i;
        sum = 0;
        window_q[w][wpos_q[w]] = v;
        wpos_q[w] = (wpos_q[w] + 1) % WIN_DEPTH;
        if (fill_q[w] < WIN_DEPTH)
            fill_q[w]++;
        for (i = 0; i < fill_q[w]; i++)
        begin
            if (w == WIN_TEMP)
                sum += int'($signed(window_q[w][i]));
            else
                sum += int'(window_q[w][i]);
        end
        return sum / fill_q[w];
    endfunction

    function automatic void mark_channel(logic [1:0] ch, bit good);
        int c;
        c = int'(ch);
        if (good)
        begin
            status_q[c]     = 1'b0;
            status_q[c + 4] = 1'b0;
            fail_cnt_q[c]   = 0;
        end
        else
        begin
            status_q[c] = 1'b1;
            if (fail_cnt_q[c] < int'(FAIL_SAT))
            begin
                fail_cnt_q[c]++;
                if (fail_cnt_q[c] >= int'(fail_limit_q))
                    status_q[c + 4] = 1'b1;
            end
        end
    endfunction

    function automatic snapshot_t predict_snapshot(logic [2:0] op, logic ok, logic [15:0] rd,
                                                   logic signed [15:0] temp, logic [11:0] adc,
                                                   logic [31:0] now);
        snapshot_t   snap;
        logic [31:0] age;
        int          avg;
        case (op)
            OP_CO2:
            begin
                if (ok && rd != 16'd0 && rd <= co2_max_q)
                begin
                    co2_q       = rd;
                    co2_seen_ms = now;
                    mark_channel(CH_CO2, 1'b1);
                end
                else
                    mark_channel(CH_CO2, 1'b0);
            end
            OP_CO2_POLL:
            begin
                age = now - co2_seen_ms;
                if (age >= {16'd0, stale_q})
                    mark_channel(CH_CO2, 1'b0);
            end
            OP_LIGHT:
            begin
                if (ok && adc != ADC_SAT)
                begin
                    avg   = push_sample(WIN_LUX, rd);
                    lux_q = avg[15:0];
                    mark_channel(CH_LIGHT, 1'b1);
                end
                else
                    mark_channel(CH_LIGHT, 1'b0);
            end
            OP_SOIL:
            begin
                if (ok)
                begin
                    avg    = push_sample(WIN_SOIL, rd);
                    soil_q = avg[15:0];
                    mark_channel(CH_SOIL, 1'b1);
                end
                else
                    mark_channel(CH_SOIL, 1'b0);
            end
            OP_CLIMATE:
            begin
                if (ok && temp >= TEMP_MIN && temp <= TEMP_MAX && rd <= HUM_MAX)
                begin
                    avg    = push_sample(WIN_TEMP, temp);
                    temp_q = avg[15:0];
                    avg    = push_sample(WIN_HUM, rd);
                    hum_q  = avg[15:0];
                    mark_channel(CH_CLIMATE, 1'b1);
                end
                else
                    mark_channel(CH_CLIMATE, 1'b0);
            end
            default: ;
        endcase
        snap.co2    = co2_q;
        snap.lux    = lux_q;
        snap.soil   = soil_q;
        snap.temp   = temp_q[10:0];
        snap.hum    = hum_q[9:0];
        snap.status = status_q;
        return snap;
    endfunction

    function automatic void check_field(string field, longint expected, longint actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            expected_snapshots.delete();
            fail_count    = 0;
            checked_words = 0;
            pending_words = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    write_register(paddr[3:2], pwdata);
                else
                    check_field("prdata", read_register(paddr[3:2]), prdata);
            end
            if (out_valid && out_ready)
            begin
                if (expected_snapshots.size() == 0)
                begin
                    $error("result word with no event pending");
                    fail_count++;
                end
                else
                begin
                    exp_snap = expected_snapshots.pop_front();
                    check_field("co2_value", exp_snap.co2, co2_value);
                    check_field("lux_avg", exp_snap.lux, lux_avg);
                    check_field("soil_avg", exp_snap.soil, soil_avg);
                    check_field("temp_avg", $signed(exp_snap.temp), temp_avg);
                    check_field("humidity_avg", exp_snap.hum, humidity_avg);
                    check_field("status_bits", exp_snap.status, status_bits);
                    checked_words++;
                end
            end
            if (in_valid && in_ready)
                expected_snapshots.push_back(predict_snapshot(opcode, read_ok, reading,
                                                              temp_tenths_in, light_adc_raw,
                                                              now_ms));
            pending_words = expected_snapshots.size();
        end
    end

endmodule

/* dv/sensor_channel_conditioner_core_tb.sv */
`timescale 1ns / 100ps
// Top of the sensor channel conditioner test: clock, reset, register setup over APB and
// bursty event stimulus with a stalling result sink. Depends on scc_pkg, the block and
// scc_snapshot_checker, which does all prediction and comparison.

module sensor_channel_conditioner_core_tb;

    import scc_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    wire  [31:0]        prdata;
    wire                pready;
    logic               in_valid;
    wire                in_ready;
    logic [2:0]         opcode;
    logic               read_ok;
    logic [15:0]        reading;
    logic signed [15:0] temp_tenths_in;
    logic [11:0]        light_adc_raw;
    logic [31:0]        now_ms;
    wire                out_valid;
    logic               out_ready;
    wire  [15:0]        co2_value;
    wire  [15:0]        lux_avg;
    wire  [15:0]        soil_avg;
    wire signed [10:0]  temp_avg;
    wire  [9:0]         humidity_avg;
    wire  [7:0]         status_bits;

    int                 fail_count;
    int                 pending_words;
    int                 checked_words;

    int                 burst_left = 0;
    int                 words_sent = 0;
    int                 settings_used = 1;
    int                 stall_mode = 0;
    int                 stall_left = 0;
    int                 sink_cycle = 0;
    logic [15:0]        cur_co2_max;
    logic [31:0]        clock_ms;

    sensor_channel_conditioner_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .read_ok        (read_ok),
        .reading        (reading),
        .temp_tenths_in (temp_tenths_in),
        .light_adc_raw  (light_adc_raw),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .co2_value      (co2_value),
        .lux_avg        (lux_avg),
        .soil_avg       (soil_avg),
        .temp_avg       (temp_avg),
        .humidity_avg   (humidity_avg),
        .status_bits    (status_bits)
    );

    scc_snapshot_checker snap_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .read_ok        (read_ok),
        .reading        (reading),
        .temp_tenths_in (temp_tenths_in),
        .light_adc_raw  (light_adc_raw),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .co2_value      (co2_value),
        .lux_avg        (lux_avg),
        .soil_avg       (soil_avg),
        .temp_avg       (temp_avg),
        .humidity_avg   (humidity_avg),
        .status_bits    (status_bits),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .checked_words  (checked_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result sink: switch between full rate, light, heavy and periodic stalls
    always @(negedge clk)
    begin
        sink_cycle++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((sink_cycle % 7) >= 3);
        endcase
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_event(input logic [2:0] op, input logic ok, input logic [15:0] rd,
                              input logic signed [15:0] temp, input logic [11:0] adc,
                              input logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0 && in_valid)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid       <= 1'b1;
        opcode         <= op;
        read_ok        <= ok;
        reading        <= rd;
        temp_tenths_in <= temp;
        light_adc_raw  <= adc;
        now_ms         <= now;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_events();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_words != 0) @(negedge clk);
    endtask

    task automatic reconfigure(input logic [15:0] co2_max, input logic [7:0] limit,
                               input logic [15:0] stale);
        drain_events();
        apb_access(1'b1, REG_CO2_MAX, {16'd0, co2_max});
        apb_access(1'b1, REG_FAIL_LIMIT, {24'd0, limit});
        apb_access(1'b1, REG_CO2_STALE, {16'd0, stale});
        apb_access(1'b0, REG_CO2_MAX, 32'd0);
        apb_access(1'b0, REG_FAIL_LIMIT, 32'd0);
        apb_access(1'b0, REG_CO2_STALE, 32'd0);
        cur_co2_max = co2_max;
        settings_used++;
    endtask

    // mostly well-formed events with random content; light_heavy floods failed light reads
    task automatic random_event(input bit light_heavy);
        int                 kind;
        int                 pick;
        bit                 good;
        logic [2:0]         op;
        logic               ok;
        logic [15:0]        rd;
        logic signed [15:0] temp;
        logic [11:0]        adc;
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 4000);
        rd   = 16'($urandom);
        temp = 16'($urandom);
        adc  = 12'($urandom);
        ok   = 1'b1;
        kind = $urandom_range(0, 99);
        good = (kind >= 20);
        if (light_heavy && kind < 85)
        begin
            op   = OP_LIGHT;
            good = 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = OP_UNUSED_LO + 3'($urandom_range(0, 2));
            else
                op = 3'($urandom_range(0, 4));
        end
        case (op)
            OP_CO2:
            begin
                if (good)
                    rd = 16'($urandom_range(1, cur_co2_max));
                else
                begin
                    case ($urandom_range(0, 2))
                        0: ok = 1'b0;
                        1: rd = 16'd0;
                        default:
                            rd = (cur_co2_max == 16'hFFFF) ? 16'd0
                                 : 16'($urandom_range(cur_co2_max + 1, 65535));
                    endcase
                end
            end
            OP_LIGHT:
            begin
                if (good)
                    adc = 12'($urandom_range(0, 4094));
                else if ($urandom_range(0, 1) == 0)
                begin
                    adc = ADC_SAT;
                    ok  = 1'($urandom);
                end
                else
                    ok = 1'b0;
            end
            OP_SOIL:
                ok = good;
            OP_CLIMATE:
            begin
                temp = 16'($urandom_range(0, 1200) - 400);
                rd   = 16'($urandom_range(0, 1000));
                if (!good)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            ok   = 1'b0;
                            temp = 16'($urandom);
                            rd   = 16'($urandom);
                        end
                        1: temp = 16'($urandom_range(801, 32767));
                        2: temp = 16'(32'd0 - $urandom_range(401, 32768));
                        default: rd = 16'($urandom_range(1001, 65535));
                    endcase
                end
            end
            default:
                ok = 1'($urandom);
        endcase
        send_event(op, ok, rd, temp, adc, clock_ms);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        opcode         = OP_CO2;
        read_ok        = 1'b0;
        reading        = '0;
        temp_tenths_in = '0;
        light_adc_raw  = '0;
        now_ms         = '0;
        out_ready      = 1'b0;
        cur_co2_max    = CO2_MAX_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // poll before and at the stale limit, fail CO2 up to the fault limit, then probe channel bounds
        send_event(OP_CO2_POLL, 1'b1, 16'd0, 16'sd0, 12'd0, 32'd100);
        send_event(OP_CO2_POLL, 1'b0, 16'hFFFF, -16'sd1, ADC_SAT, 32'd5000);
        send_event(OP_CO2, 1'b1, 16'd0, 16'sd0, 12'd0, 32'd5100);
        send_event(OP_CO2, 1'b1, 16'd5001, 16'sd0, 12'd0, 32'd5200);
        send_event(OP_CO2, 1'b1, 16'd5000, 16'sd0, 12'd0, 32'd6000);
        send_event(OP_CO2, 1'b1, 16'd1, 16'sd0, 12'd0, 32'd6100);
        send_event(OP_LIGHT, 1'b1, 16'd777, 16'sd0, ADC_SAT, 32'd6200);
        send_event(OP_LIGHT, 1'b0, 16'd777, 16'sd0, 12'd10, 32'd6300);
        send_event(OP_LIGHT, 1'b1, 16'hFFFF, 16'sd0, 12'd4094, 32'd6400);
        send_event(OP_LIGHT, 1'b1, 16'd0, 16'sd0, 12'd0, 32'd6500);
        send_event(OP_SOIL, 1'b0, 16'd123, 16'sd0, 12'd0, 32'd6600);
        send_event(OP_SOIL, 1'b1, 16'hFFFF, 16'sd0, 12'd0, 32'd6700);
        send_event(OP_CLIMATE, 1'b1, 16'd0, -16'sd400, 12'd0, 32'd6800);
        send_event(OP_CLIMATE, 1'b1, 16'd1, -16'sd1, 12'd0, 32'd6900);
        send_event(OP_CLIMATE, 1'b1, 16'd1000, 16'sd800, 12'd0, 32'd7000);
        send_event(OP_CLIMATE, 1'b1, 16'd500, -16'sd401, 12'd0, 32'd7100);
        send_event(OP_CLIMATE, 1'b1, 16'd500, 16'sd801, 12'd0, 32'd7200);
        send_event(OP_CLIMATE, 1'b1, 16'd1001, 16'sd0, 12'd0, 32'd7300);
        send_event(OP_CLIMATE, 1'b0, 16'd500, 16'sd0, 12'd0, 32'd7400);
        send_event(OP_CLIMATE, 1'b1, 16'hFFFF, -16'sd32768, 12'd0, 32'd7500);
        send_event(OP_UNUSED_LO, 1'b1, 16'd1, 16'sd1, 12'd1, 32'd7600);
        send_event(OP_UNUSED_HI, 1'b0, 16'hFFFF, -16'sd1, ADC_SAT, 32'hFFFF_FFFF);
        // age across the 32-bit wrap stays below the stale limit
        send_event(OP_CO2, 1'b1, 16'd400, 16'sd0, 12'd0, 32'hFFFF_FF00);
        send_event(OP_CO2_POLL, 1'b1, 16'd0, 16'sd0, 12'd0, 32'h0000_0100);
        clock_ms = 32'h0000_0100;

        reconfigure(16'hFFFF, 8'd1, 16'd0);
        repeat (200) random_event(1'b0);

        reconfigure(16'd1, 8'd255, 16'hFFFF);
        repeat (340) random_event(1'b1);

        reconfigure(16'($urandom_range(500, 10000)), 8'($urandom_range(2, 8)),
                    16'($urandom_range(1000, 20000)));
        clock_ms = 32'hFFFF_0000;
        repeat (300) random_event(1'b0);

        drain_events();
        repeat (40) @(negedge clk);

        $display("Run covered %0d event words under %0d register settings", words_sent,
                 settings_used);
        $display("%0d snapshots compared against the predictor", checked_words);
        if (fail_count == 0)
            $display("sensor_channel_conditioner_core test passed");
        else
            $display("sensor_channel_conditioner_core test failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("sensor_channel_conditioner_core test failed");
        $finish;
    end

endmodule

/* files.f */
src/scc_pkg.sv
src/scc_ram.sv
src/scc_serdiv.sv
src/scc_window.sv
src/sensor_channel_conditioner_core.sv
dv/scc_snapshot_checker.sv
dv/sensor_channel_conditioner_core_tb.sv
